FILE: design/uvs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared types, constants and trig helpers of the UV sphere quad generator.
// ----------------------------------------------------------------------------
package uvs_pkg;

	localparam int TRIG_FRAC_BITS = 15;
	localparam int MW = TRIG_FRAC_BITS + 1;

	localparam int QDEPTH = 2;
	localparam int QPW = $clog2(QDEPTH);
	localparam int QCW = $clog2(QDEPTH + 1);

	localparam logic [7:0] STEP_MAX = 8'd180;
	localparam logic [3:0] VERT_RECS = 4'd4;
	localparam logic [3:0] REC_LAST = 4'd9;

	localparam longint unsigned PI_Q30 = 64'd3373259426;
	localparam longint ONE_Q30 = 64'sd1 <<< 30;

	typedef enum logic {
		REG_RADIUS = 1'b0,
		REG_STEP   = 1'b1
	} cfg_reg_e;

	typedef enum logic {
		KIND_VERTEX = 1'b0,
		KIND_INDEX  = 1'b1
	} kind_e;

	typedef struct packed {
		logic [8:0]  lon;
		logic [7:0]  lat;
		logic [7:0]  step;
		logic [17:0] base;
		logic        done;
	} quad_t;

	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

	typedef struct packed {
		logic          neg;
		logic [MW-1:0] mag;
	} trig_t;

	typedef logic [90:0][MW-1:0] sin_rom_t;

	function automatic longint unsigned taylor_div(longint unsigned term, int n);
		case (n)
			1:       return term / 64'd6;
			2:       return term / 64'd20;
			3:       return term / 64'd42;
			4:       return term / 64'd72;
			5:       return term / 64'd110;
			6:       return term / 64'd156;
			7:       return term / 64'd210;
			8:       return term / 64'd272;
			9:       return term / 64'd342;
			10:      return term / 64'd420;
			11:      return term / 64'd506;
			12:      return term / 64'd600;
			default: return term;
		endcase
	endfunction

	function automatic logic [MW-1:0] sine_entry(int k);
		longint unsigned x;
		longint unsigned term;
		longint sum;
		x = (longint'(k) * PI_Q30 + 64'd90) / 64'd180;
		term = x;
		sum = longint'(x);
		for (int n = 1; n <= 12; n++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = taylor_div(term, n);
			if (n % 2 == 1) sum = sum - longint'(term);
			else sum = sum + longint'(term);
		end
		if (sum < 0) sum = 0;
		if (sum > ONE_Q30) sum = ONE_Q30;
		sum = (sum + (64'sd1 <<< (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
		return MW'(sum);
	endfunction

	function automatic sin_rom_t build_sin_rom();
		sin_rom_t rom;
		for (int k = 0; k <= 90; k++) rom[k] = sine_entry(k);
		return rom;
	endfunction

	localparam sin_rom_t SIN_ROM = build_sin_rom();

	// sine of a whole-degree angle below 1024, as sign and magnitude
	function automatic trig_t trig_lookup(logic [9:0] d);
		logic [9:0] m;
		logic [6:0] k;
		trig_t t;
		if (d >= 10'd720) m = d - 10'd720;
		else if (d >= 10'd360) m = d - 10'd360;
		else m = d;
		priority if (m <= 10'd90) begin
			k = m[6:0];
			t.neg = 1'b0;
		end else if (m <= 10'd180) begin
			k = 7'(10'd180 - m);
			t.neg = 1'b0;
		end else if (m <= 10'd270) begin
			k = 7'(m - 10'd180);
			t.neg = 1'b1;
		end else begin
			k = 7'(10'd360 - m);
			t.neg = 1'b1;
		end
		t.mag = SIN_ROM[k];
		return t;
	endfunction

	// vertex offsets of the two triangles of a quad
	function automatic logic [1:0] idx_offset(logic [2:0] k);
		case (k)
			3'd0:    return 2'd0;
			3'd1:    return 2'd1;
			3'd2:    return 2'd3;
			3'd3:    return 2'd0;
			3'd4:    return 2'd3;
			3'd5:    return 2'd2;
			default: return 2'd0;
		endcase
	endfunction

endpackage

FILE: design/uvs_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_ifs
// Command and record channels of the UV sphere quad generator.
// ----------------------------------------------------------------------------
interface uvs_cmd_if;
	logic valid;
	logic ready;
	logic restart;

	modport source(output valid, output restart, input ready);
	modport sink(input valid, input restart, output ready);
endinterface

interface uvs_rec_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic signed [16:0] pos_x;
	logic signed [16:0] pos_y;
	logic signed [16:0] pos_z;
	logic [16:0]        tex_u;
	logic [16:0]        tex_v;
	logic signed [15:0] norm_x;
	logic signed [15:0] norm_y;
	logic signed [15:0] norm_z;
	logic [17:0]        vertex_index;
	logic               quad_last;
	logic               mesh_done;

	modport source(output valid, output kind, output pos_x, output pos_y, output pos_z,
		output tex_u, output tex_v, output norm_x, output norm_y, output norm_z,
		output vertex_index, output quad_last, output mesh_done, input ready);
	modport sink(input valid, input kind, input pos_x, input pos_y, input pos_z,
		input tex_u, input tex_v, input norm_x, input norm_y, input norm_z,
		input vertex_index, input quad_last, input mesh_done, output ready);
endinterface

FILE: design/uvs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_front
// Accepts command beats, walks the grid and pushes one quad descriptor each.
// ----------------------------------------------------------------------------
module uvs_front import uvs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] step,
	uvs_cmd_if.sink    cmd,
	input  qstat_t     qstat,
	output logic       push,
	output quad_t      quad
);

	logic [7:0]  lat_q;
	logic [8:0]  lon_q;
	logic [17:0] base_q;

	logic [7:0]  s;
	logic [8:0]  a;
	logic [7:0]  b;
	logic [17:0] base;
	logic        row_end;
	logic        done;

	assign cmd.ready = !qstat.full;
	assign push = cmd.valid && cmd.ready;

	always_comb begin
		priority if (step == 8'd0) s = 8'd1;
		else if (step > STEP_MAX) s = STEP_MAX;
		else s = step;
		a = cmd.restart ? 9'd0 : lon_q;
		b = cmd.restart ? 8'd0 : lat_q;
		base = cmd.restart ? 18'd0 : base_q;
		row_end = ({1'b0, a} + {1'b0, s, 1'b0}) > 10'd360;
		done = row_end && (({2'b0, b} + {1'b0, s, 1'b0}) > 10'd180);
		quad.lon = a;
		quad.lat = b;
		quad.step = s;
		quad.base = base;
		quad.done = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_q <= '0;
			lon_q <= '0;
			base_q <= '0;
		end else if (push) begin
			priority if (done) begin
				lat_q <= '0;
				lon_q <= '0;
				base_q <= '0;
			end else if (row_end) begin
				lon_q <= '0;
				lat_q <= b + s;
				base_q <= base + 18'd4;
			end else begin
				lon_q <= a + {1'b0, s};
				lat_q <= b;
				base_q <= base + 18'd4;
			end
		end
	end

endmodule

FILE: design/uvs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_queue
// Short FIFO of quad descriptors between the front and the back.
// ----------------------------------------------------------------------------
module uvs_queue import uvs_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  quad_t  wdata,
	input  logic   pop,
	output quad_t  head,
	output qstat_t stat
);

	quad_t          mem_q [QDEPTH];
	logic [QPW-1:0] wr_q;
	logic [QPW-1:0] rd_q;
	logic [QCW-1:0] cnt_q;

	assign head = mem_q[rd_q];
	assign stat.empty = (cnt_q == '0);
	assign stat.full = (cnt_q == QCW'(QDEPTH));

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == QPW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == QPW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: design/uvs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_back
// Issues ten records per quad into a stalling pipeline: trig lookup and
// texture scaling, direction products, radius products, rounding.
// ----------------------------------------------------------------------------
module uvs_back import uvs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] radius,
	input  qstat_t      qstat,
	input  quad_t       head,
	output logic        pop,
	uvs_rec_if.source   rec
);

	localparam int TEX_SH = 34;
	localparam logic [63:0] TEX_ONE = 64'd1 << TEX_SH;
	localparam logic [26:0] DIV_U = 27'((TEX_ONE + 64'd359) / 64'd360);
	localparam logic [26:0] DIV_V = 27'((TEX_ONE + 64'd179) / 64'd180);
	localparam int PRW = 53;
	localparam logic [16:0] TEX_FULL = 17'd65536;

	localparam int DW = 2 * MW;
	localparam int PW = 16 + DW;
	localparam int YW = 16 + MW;
	localparam int NS = 2 * TRIG_FRAC_BITS - 15;
	localparam int NY_SH = (TRIG_FRAC_BITS > 15) ? TRIG_FRAC_BITS - 15 : 0;
	localparam int NY_SL = (TRIG_FRAC_BITS < 15) ? 15 - TRIG_FRAC_BITS : 0;
	localparam int NYW = MW + NY_SL + 1;
	localparam logic [63:0] HALF_P = 64'd1 << (2 * TRIG_FRAC_BITS - 1);
	localparam logic [63:0] HALF_Y = 64'd1 << (TRIG_FRAC_BITS - 1);
	localparam logic [63:0] HALF_N = 64'd1 << (NS - 1);
	localparam logic [63:0] HALF_NY = (64'd1 << NY_SH) >> 1;

	function automatic logic signed [16:0] signed17(logic neg, logic [15:0] m);
		return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
	endfunction

	function automatic logic signed [15:0] signed16(logic neg, logic [14:0] m);
		return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
	endfunction

	logic en;
	logic issue;
	logic [3:0] cnt_q;
	logic v_s1, v_s2, v_s3, v_s4, out_valid_q;

	// issue
	logic        vert;
	logic [9:0]  aa_d;
	logic [8:0]  bb_d;
	logic [17:0] idx_d;

	// stage 1
	logic        kind_s1, last_s1, done_s1;
	logic [17:0] idx_s1;
	logic [9:0]  aa_s1;
	logic [8:0]  bb_s1;

	// stage 2
	trig_t sa, ca, sb, cb;
	logic [25:0] nu, nv;
	logic [PRW-1:0] pu, pv;
	logic        kind_s2, last_s2, done_s2;
	logic [17:0] idx_s2;
	trig_t sa_s2, ca_s2, sb_s2, cb_s2;
	logic [PRW-TEX_SH-1:0] qu_s2, qv_s2;

	// stage 3
	logic        kind_s3, last_s3, done_s3;
	logic [17:0] idx_s3;
	logic [DW-1:0] px_s3, pz_s3;
	logic [MW-1:0] cbm_s3;
	logic        nx_neg_s3, ny_neg_s3, nz_neg_s3;
	logic [16:0] tu_s3, tv_s3;

	// stage 4
	logic [DW:0]  nxr, nzr;
	logic [NYW-1:0] nyr;
	logic [DW:0]  nxq, nzq;
	logic [NYW-1:0] nyq;
	logic        kind_s4, last_s4, done_s4;
	logic [17:0] idx_s4;
	logic [PW-1:0] rx_s4, rz_s4;
	logic [YW-1:0] ry_s4;
	logic        nx_neg_s4, ny_neg_s4, nz_neg_s4;
	logic [16:0] tu_s4, tv_s4;
	logic signed [15:0] nx_s4, ny_s4, nz_s4;

	// output
	logic [PW:0] rxr, rzr;
	logic [YW:0] ryr;
	logic [PW:0] rxq, rzq;
	logic [YW:0] ryq;
	logic [15:0] mx, my, mz;

	assign en = !out_valid_q || rec.ready;
	assign issue = en && !qstat.empty;
	assign pop = issue && (cnt_q == REC_LAST);

	always_comb begin
		vert = cnt_q < VERT_RECS;
		aa_d = {1'b0, head.lon} + (cnt_q[1] ? {2'b0, head.step} : 10'd0);
		bb_d = {1'b0, head.lat} + (cnt_q[0] ? {1'b0, head.step} : 9'd0);
		idx_d = vert ? 18'd0 : head.base + 18'(idx_offset(3'(cnt_q - VERT_RECS)));
	end

	always_comb begin
		sa = trig_lookup(aa_s1);
		ca = trig_lookup(aa_s1 + 10'd90);
		sb = trig_lookup({1'b0, bb_s1});
		cb = trig_lookup({1'b0, bb_s1} + 10'd90);
		nu = {aa_s1, 16'd0} + 26'd180;
		nv = {1'b0, bb_s1, 16'd0} + 26'd90;
		pu = PRW'(nu) * PRW'(DIV_U);
		pv = PRW'(nv) * PRW'(DIV_V);
	end

	always_comb begin
		nxr = {1'b0, px_s3} + (DW + 1)'(HALF_N);
		nzr = {1'b0, pz_s3} + (DW + 1)'(HALF_N);
		nyr = (NYW'(cbm_s3) << NY_SL) + NYW'(HALF_NY);
		nxq = nxr >> NS;
		nzq = nzr >> NS;
		nyq = nyr >> NY_SH;
	end

	always_comb begin
		rxr = {1'b0, rx_s4} + (PW + 1)'(HALF_P);
		rzr = {1'b0, rz_s4} + (PW + 1)'(HALF_P);
		ryr = {1'b0, ry_s4} + (YW + 1)'(HALF_Y);
		rxq = rxr >> (2 * TRIG_FRAC_BITS);
		rzq = rzr >> (2 * TRIG_FRAC_BITS);
		ryq = ryr >> TRIG_FRAC_BITS;
		mx = (rxq > (PW + 1)'(65535)) ? 16'hFFFF : rxq[15:0];
		mz = (rzq > (PW + 1)'(65535)) ? 16'hFFFF : rzq[15:0];
		my = (ryq > (YW + 1)'(65535)) ? 16'hFFFF : ryq[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			if (issue) cnt_q <= pop ? 4'd0 : cnt_q + 4'd1;
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= vert ? KIND_VERTEX : KIND_INDEX;
			last_s1 <= cnt_q == REC_LAST;
			done_s1 <= head.done;
			idx_s1 <= idx_d;
			aa_s1 <= aa_d;
			bb_s1 <= bb_d;

			kind_s2 <= kind_s1;
			last_s2 <= last_s1;
			done_s2 <= done_s1;
			idx_s2 <= idx_s1;
			sa_s2 <= sa;
			ca_s2 <= ca;
			sb_s2 <= sb;
			cb_s2 <= cb;
			qu_s2 <= pu[PRW-1:TEX_SH];
			qv_s2 <= pv[PRW-1:TEX_SH];

			kind_s3 <= kind_s2;
			last_s3 <= last_s2;
			done_s3 <= done_s2;
			idx_s3 <= idx_s2;
			px_s3 <= DW'(sa_s2.mag) * DW'(sb_s2.mag);
			pz_s3 <= DW'(ca_s2.mag) * DW'(sb_s2.mag);
			cbm_s3 <= cb_s2.mag;
			nx_neg_s3 <= sa_s2.neg ^ sb_s2.neg;
			nz_neg_s3 <= ca_s2.neg ^ sb_s2.neg;
			ny_neg_s3 <= cb_s2.neg;
			tu_s3 <= (qu_s2 > 19'(TEX_FULL)) ? TEX_FULL : qu_s2[16:0];
			tv_s3 <= (qv_s2 > 19'(TEX_FULL)) ? TEX_FULL : qv_s2[16:0];

			kind_s4 <= kind_s3;
			last_s4 <= last_s3;
			done_s4 <= done_s3;
			idx_s4 <= idx_s3;
			rx_s4 <= PW'(radius) * PW'(px_s3);
			rz_s4 <= PW'(radius) * PW'(pz_s3);
			ry_s4 <= YW'(radius) * YW'(cbm_s3);
			nx_neg_s4 <= nx_neg_s3;
			ny_neg_s4 <= ny_neg_s3;
			nz_neg_s4 <= nz_neg_s3;
			tu_s4 <= tu_s3;
			tv_s4 <= tv_s3;
			nx_s4 <= signed16(nx_neg_s3,
				(nxq > (DW + 1)'(32767)) ? 15'h7FFF : nxq[14:0]);
			nz_s4 <= signed16(nz_neg_s3,
				(nzq > (DW + 1)'(32767)) ? 15'h7FFF : nzq[14:0]);
			ny_s4 <= signed16(ny_neg_s3,
				(nyq > NYW'(32767)) ? 15'h7FFF : nyq[14:0]);

			rec.kind <= kind_s4;
			rec.vertex_index <= idx_s4;
			rec.quad_last <= last_s4;
			rec.mesh_done <= done_s4;
			if (kind_s4 == KIND_INDEX) begin
				rec.pos_x <= '0;
				rec.pos_y <= '0;
				rec.pos_z <= '0;
				rec.tex_u <= '0;
				rec.tex_v <= '0;
				rec.norm_x <= '0;
				rec.norm_y <= '0;
				rec.norm_z <= '0;
			end else begin
				rec.pos_x <= signed17(nx_neg_s4, mx);
				rec.pos_y <= signed17(ny_neg_s4, my);
				rec.pos_z <= signed17(nz_neg_s4, mz);
				rec.tex_u <= tu_s4;
				rec.tex_v <= tv_s4;
				rec.norm_x <= nx_s4;
				rec.norm_y <= ny_s4;
				rec.norm_z <= nz_s4;
			end
		end
	end

	assign rec.valid = out_valid_q;

endmodule

FILE: design/uv_sphere_quad_generator_top.sv
`timescale 1ns / 1ps
// A command's first record passes the queue, stages s1 to s4 and the output register.
// Throughput: one record per cycle while rec.ready holds, set by the back
// end issue counter that steps through the four vertices and six indices.
// A two-entry descriptor queue lets commands be taken while records drain.
// Reset: walk at the grid origin, radius 1.0, step 10 degrees, pipeline empty.
// ----------------------------------------------------------------------------
// uv_sphere_quad_generator_top
// UV sphere tessellator: front walks the grid, back emits quad records.
// ----------------------------------------------------------------------------
module uv_sphere_quad_generator_top import uvs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_en,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data,
	uvs_cmd_if.sink     cmd,
	uvs_rec_if.source   rec
);

	logic [15:0] radius_q;
	logic [7:0]  step_q;

	logic   push;
	logic   pop;
	quad_t  quad;
	quad_t  head;
	qstat_t qstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 16'd256;
			step_q <= 8'd10;
		end else if (cfg_en) begin
			unique case (cfg_reg_e'(cfg_index))
				REG_RADIUS: radius_q <= cfg_data;
				REG_STEP:   step_q <= cfg_data[7:0];
			endcase
		end
	end

	uvs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step_q),
		.cmd    (cmd),
		.qstat  (qstat),
		.push   (push),
		.quad   (quad)
	);

	uvs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (quad),
		.pop    (pop),
		.head   (head),
		.stat   (qstat)
	);

	uvs_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.radius (radius_q),
		.qstat  (qstat),
		.head   (head),
		.pop    (pop),
		.rec    (rec)
	);

`ifndef SYNTHESIS
	a_last_is_index: assert property (@(posedge clk) disable iff (!arst_n)
		rec.valid && rec.quad_last |-> rec.kind == KIND_INDEX)
		else $error("quad_last on a vertex record");

	a_vertex_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rec.valid && rec.kind == KIND_VERTEX |-> rec.vertex_index == 18'd0)
		else $error("vertex record carries an index");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.ready |-> qstat.full)
		else $error("command stalled with room in the queue");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("descriptor popped from an empty queue");
`endif

endmodule

FILE: tb/uv_sphere_quad_generator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uv_sphere_quad_generator_top_tb
// Sends walk and restart commands to the generator under random handshake gaps and
// changing radius and step settings. A checker tracks the grid walk, predicts
// the four vertex and six index beats of every quad, and compares each
// received beat field by field.
// ----------------------------------------------------------------------------
module uv_sphere_quad_generator_top_tb;
	import uvs_pkg::*;

	localparam int FRAC = TRIG_FRAC_BITS;
	localparam longint unsigned PI_FIXED30 = 64'd3373259426;
	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam int unsigned RANDOM_CMDS = 440;

	typedef struct {
		kind_e              kind;
		logic signed [16:0] pos_x;
		logic signed [16:0] pos_y;
		logic signed [16:0] pos_z;
		logic [16:0]        tex_u;
		logic [16:0]        tex_v;
		logic signed [15:0] norm_x;
		logic signed [15:0] norm_y;
		logic signed [15:0] norm_z;
		logic [17:0]        vertex_index;
		logic               quad_last;
		logic               mesh_done;
	} mesh_rec_t;

	class sphere_mesh_checker;
		int unsigned radius_q88;
		int unsigned step_deg;
		int unsigned lat_deg;
		int unsigned lon_deg;
		logic [17:0] vertex_base;
		longint      sine_q[0:90];
		mesh_rec_t   pending_records[$];
		int          mismatches;

		function new();
			for (int k = 0; k <= 90; k++) sine_q[k] = taylor_sine(k);
			radius_q88 = 256;
			step_deg = 10;
			lat_deg = 0;
			lon_deg = 0;
			vertex_base = '0;
			mismatches = 0;
		endfunction

		function longint taylor_sine(int unsigned k);
			longint unsigned x;
			longint unsigned term;
			longint sum;
			x = (64'(k) * PI_FIXED30 + 64'd90) / 64'd180;
			term = x;
			sum = longint'(x);
			for (int n = 1; n <= 12; n++) begin
				term = (term * x) >> 30;
				term = (term * x) >> 30;
				term = term / 64'((2 * n) * (2 * n + 1));
				if (n % 2 == 1) sum = sum - longint'(term);
				else sum = sum + longint'(term);
			end
			if (sum < 0) sum = 0;
			if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
			return (sum + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
		endfunction

		function longint sin_deg(int unsigned d);
			d = d % 360;
			if (d <= 90) return sine_q[d];
			if (d <= 180) return sine_q[180 - d];
			if (d <= 270) return -sine_q[d - 180];
			return -sine_q[360 - d];
		endfunction

		function longint round_sat(longint v, int sh, longint lim);
			bit neg;
			longint unsigned mag;
			neg = v < 0;
			mag = neg ? longint'(-v) : longint'(v);
			if (sh > 0) mag = (mag + (64'd1 << (sh - 1))) >> sh;
			else if (sh < 0) mag = mag << (-sh);
			if (mag > longint'(lim)) mag = lim;
			return neg ? -longint'(mag) : longint'(mag);
		endfunction

		function mesh_rec_t make_vertex(int unsigned a, int unsigned b, bit done);
			mesh_rec_t r;
			longint sa, ca, sb, cb, rad;
			longint unsigned u, v;
			sa = sin_deg(a);
			ca = sin_deg(a + 90);
			sb = sin_deg(b);
			cb = sin_deg(b + 90);
			rad = radius_q88;
			u = (64'(a) * 64'd65536 + 64'd180) / 64'd360;
			v = (64'(b) * 64'd65536 + 64'd90) / 64'd180;
			if (u > 65536) u = 65536;
			if (v > 65536) v = 65536;
			r.kind = KIND_VERTEX;
			r.pos_x = 17'(round_sat(rad * sa * sb, 2 * FRAC, 65535));
			r.pos_y = 17'(round_sat(rad * cb, FRAC, 65535));
			r.pos_z = 17'(round_sat(rad * ca * sb, 2 * FRAC, 65535));
			r.tex_u = 17'(u);
			r.tex_v = 17'(v);
			r.norm_x = 16'(round_sat(sa * sb, 2 * FRAC - 15, 32767));
			r.norm_y = 16'(round_sat(cb, FRAC - 15, 32767));
			r.norm_z = 16'(round_sat(ca * sb, 2 * FRAC - 15, 32767));
			r.vertex_index = '0;
			r.quad_last = 1'b0;
			r.mesh_done = done;
			return r;
		endfunction

		function mesh_rec_t make_index(logic [17:0] idx, bit last, bit done);
			mesh_rec_t r;
			r.kind = KIND_INDEX;
			r.pos_x = '0;
			r.pos_y = '0;
			r.pos_z = '0;
			r.tex_u = '0;
			r.tex_v = '0;
			r.norm_x = '0;
			r.norm_y = '0;
			r.norm_z = '0;
			r.vertex_index = idx;
			r.quad_last = last;
			r.mesh_done = done;
			return r;
		endfunction

		function void add_expected(mesh_rec_t r);
			pending_records = {pending_records, r};
		endfunction

		function void note_command(bit restart);
			int unsigned corner_order[6] = '{0, 1, 3, 0, 3, 2};
			int unsigned s, a, b;
			bit row_end, done;
			s = step_deg;
			if (s == 0) s = 1;
			if (s > 180) s = 180;
			if (restart) begin
				lat_deg = 0;
				lon_deg = 0;
				vertex_base = '0;
			end
			a = lon_deg;
			b = lat_deg;
			row_end = a + 2 * s > 360;
			done = row_end && (b + 2 * s > 180);
			add_expected(make_vertex(a, b, done));
			add_expected(make_vertex(a, b + s, done));
			add_expected(make_vertex(a + s, b, done));
			add_expected(make_vertex(a + s, b + s, done));
			for (int k = 0; k < 6; k++)
				add_expected(make_index(vertex_base + 18'(corner_order[k]),
					k == 5, done));
			if (done) begin
				lat_deg = 0;
				lon_deg = 0;
				vertex_base = '0;
			end else begin
				if (row_end) begin
					lon_deg = 0;
					lat_deg = (b + s) & 32'hFF;
				end else begin
					lon_deg = (a + s) & 32'h1FF;
				end
				vertex_base = vertex_base + 18'd4;
			end
		endfunction

		function void cmp_field(string name, logic signed [63:0] want, logic signed [63:0] got);
			if (got !== want) begin
				mismatches++;
				$error("%s: expected %0d, actual %0d", name, want, got);
			end
		endfunction

		function void check_record(mesh_rec_t got);
			mesh_rec_t want;
			if (pending_records.size() == 0) begin
				mismatches++;
				$error("record beat with no quad pending");
				return;
			end
			want = pending_records.pop_front();
			cmp_field("kind", want.kind, got.kind);
			cmp_field("pos_x", want.pos_x, got.pos_x);
			cmp_field("pos_y", want.pos_y, got.pos_y);
			cmp_field("pos_z", want.pos_z, got.pos_z);
			cmp_field("tex_u", want.tex_u, got.tex_u);
			cmp_field("tex_v", want.tex_v, got.tex_v);
			cmp_field("norm_x", want.norm_x, got.norm_x);
			cmp_field("norm_y", want.norm_y, got.norm_y);
			cmp_field("norm_z", want.norm_z, got.norm_z);
			cmp_field("vertex_index", want.vertex_index, got.vertex_index);
			cmp_field("quad_last", want.quad_last, got.quad_last);
			cmp_field("mesh_done", want.mesh_done, got.mesh_done);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_en;
	logic [0:0]  cfg_index;
	logic [15:0] cfg_data;
	bit          no_idle;
	int unsigned cmds_sent;

	sphere_mesh_checker mesh_chk = new();

	uvs_cmd_if cmd_ch();
	uvs_rec_if rec_ch();

	uv_sphere_quad_generator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_en    (cfg_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_ch),
		.rec       (rec_ch)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb: failure");
		$finish;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	always @(posedge clk) begin
		mesh_rec_t got;
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready) mesh_chk.note_command(cmd_ch.restart);
			if (rec_ch.valid && rec_ch.ready) begin
				got.kind = kind_e'(rec_ch.kind);
				got.pos_x = rec_ch.pos_x;
				got.pos_y = rec_ch.pos_y;
				got.pos_z = rec_ch.pos_z;
				got.tex_u = rec_ch.tex_u;
				got.tex_v = rec_ch.tex_v;
				got.norm_x = rec_ch.norm_x;
				got.norm_y = rec_ch.norm_y;
				got.norm_z = rec_ch.norm_z;
				got.vertex_index = rec_ch.vertex_index;
				got.quad_last = rec_ch.quad_last;
				got.mesh_done = rec_ch.mesh_done;
				mesh_chk.check_record(got);
			end
		end
	end

	// record sink: random stalls between ready stretches
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		rec_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left != 0) begin
				rec_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rec_ch.ready <= 1'b1;
				if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
			end
		end
	end

	task automatic send_quad_cmd(bit restart);
		int unsigned gap;
		@(negedge clk);
		cmd_ch.valid <= 1'b1;
		cmd_ch.restart <= restart;
		do @(posedge clk); while (!cmd_ch.ready);
		cmds_sent++;
		gap = pick_gap();
		if (gap != 0) begin
			@(negedge clk);
			cmd_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic await_drain();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (mesh_chk.pending_records.size() != 0) @(posedge clk);
	endtask

	task automatic set_registers(logic [15:0] radius, logic [7:0] step);
		await_drain();
		repeat (8) @(posedge clk);
		@(negedge clk);
		cfg_en <= 1'b1;
		cfg_index <= REG_RADIUS;
		cfg_data <= radius;
		@(negedge clk);
		cfg_index <= REG_STEP;
		cfg_data <= {8'd0, step};
		@(negedge clk);
		cfg_en <= 1'b0;
		mesh_chk.radius_q88 = radius;
		mesh_chk.step_deg = step;
	endtask

	initial begin
		int unsigned n;
		int unsigned pick;
		logic [15:0] radius;
		logic [7:0]  step;
		int unsigned common_steps[8];

		common_steps = '{30, 36, 40, 45, 60, 72, 90, 120};
		arst_n = 1'b0;
		cfg_en = 1'b0;
		cfg_index = REG_RADIUS;
		cfg_data = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.restart = 1'b0;
		no_idle = 1'b0;
		cmds_sent = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// walk from reset settings, then restart mid-row
		send_quad_cmd(1'b0);
		send_quad_cmd(1'b0);
		send_quad_cmd(1'b1);
		send_quad_cmd(1'b0);
		// full radius, widest step: two-quad mesh, end flag and wrap
		set_registers(16'hFFFF, 8'd180);
		send_quad_cmd(1'b1);
		send_quad_cmd(1'b0);
		send_quad_cmd(1'b0);
		// zero radius, zero step
		set_registers(16'h0000, 8'd0);
		send_quad_cmd(1'b1);
		send_quad_cmd(1'b0);
		send_quad_cmd(1'b0);
		// step above range
		set_registers(16'hFFFF, 8'd255);
		send_quad_cmd(1'b1);
		send_quad_cmd(1'b0);
		// step change mid-walk pushes angles past the grid
		set_registers(16'd256, 8'd90);
		send_quad_cmd(1'b1);
		repeat (5) send_quad_cmd(1'b0);
		set_registers(16'h8000, 8'd180);
		send_quad_cmd(1'b0);

		while (cmds_sent < RANDOM_CMDS) begin
			pick = $urandom_range(0, 5);
			case (pick)
				0:       radius = 16'h0000;
				1:       radius = 16'hFFFF;
				2:       radius = 16'd256;
				default: radius = 16'($urandom);
			endcase
			pick = $urandom_range(0, 9);
			case (pick)
				0:       step = 8'd0;
				1:       step = 8'($urandom_range(181, 255));
				2:       step = 8'd1;
				3:       step = 8'd180;
				4, 5, 6: step = 8'(common_steps[$urandom_range(0, 7)]);
				default: step = 8'($urandom_range(1, 180));
			endcase
			set_registers(radius, step);
			no_idle = ($urandom_range(0, 4) == 0);
			n = $urandom_range(15, 50);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 39) == 0) await_drain();
				send_quad_cmd($urandom_range(0, 15) == 0);
			end
		end
		no_idle = 1'b0;

		await_drain();
		repeat (20) @(posedge clk);
		if (mesh_chk.pending_records.size() != 0)
			$error("%0d record beats never arrived", mesh_chk.pending_records.size());
		if (mesh_chk.mismatches == 0 && mesh_chk.pending_records.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: files.f
design/uvs_pkg.sv
design/uvs_ifs.sv
design/uvs_front.sv
design/uvs_queue.sv
design/uvs_back.sv
design/uv_sphere_quad_generator_top.sv
tb/uv_sphere_quad_generator_top_tb.sv
